// ===== rtl/mpg_pkg.sv =====
// ---------------------------------------------------------------------------
// mpg_pkg
// Shared types and codes of the maglock pulse guard controller.
// ---------------------------------------------------------------------------
package mpg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MAX_ITEMS  = 8;

	// operations
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_OPEN  = 3'd1;
	localparam logic [2:0] OP_CLOSE = 3'd2;
	localparam logic [2:0] OP_LEVEL = 3'd3;
	localparam logic [2:0] OP_FORCE = 3'd4;

	// status codes
	localparam logic [3:0] ST_OPENED     = 4'd1;
	localparam logic [3:0] ST_BLK_BOOT   = 4'd2;
	localparam logic [3:0] ST_BLK_COOL   = 4'd3;
	localparam logic [3:0] ST_BUSY       = 4'd4;
	localparam logic [3:0] ST_CLOSED     = 4'd5;
	localparam logic [3:0] ST_LEVEL      = 4'd6;
	localparam logic [3:0] ST_PULSE_DONE = 4'd7;
	localparam logic [3:0] ST_CUTOFF     = 4'd8;
	localparam logic [3:0] ST_GUARD_CLR  = 4'd9;
	localparam logic [3:0] ST_COOL_CLR   = 4'd10;
	localparam logic [3:0] ST_REJECT     = 4'd11;
	localparam logic [3:0] ST_FORCED     = 4'd12;

	// register indexes
	localparam logic [2:0] REG_MODE_MASK = 3'd0;
	localparam logic [2:0] REG_ENABLED   = 3'd1;
	localparam logic [2:0] REG_PULSE     = 3'd2;
	localparam logic [2:0] REG_CUTOFF    = 3'd3;
	localparam logic [2:0] REG_COOLDOWN  = 3'd4;
	localparam logic [2:0] REG_GUARD     = 3'd5;
	localparam logic [2:0] REG_BOOT_TIME = 3'd6;

	typedef struct packed {
		logic [2:0]  operation;
		logic [1:0]  lock_index;
		logic [31:0] time_ms;
		logic        closed_level;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  lock_id;
		logic        coil_on;
		logic        is_pulsing;
		logic        in_cooldown;
		logic        guarded;
		logic [15:0] pulses_done;
		logic [3:0]  status;
		logic        last;
	} sts_t;

	typedef struct packed {
		logic        coil;
		logic        pulse;
		logic        cool;
		logic        guard;
		logic [31:0] pstart;
		logic [31:0] cstart;
		logic [15:0] count;
	} entry_t;

	typedef struct packed {
		logic [3:0]  mode_mask;
		logic        enabled;
		logic [19:0] pulse_ms;
		logic [19:0] cutoff_ms;
		logic [19:0] cooldown_ms;
		logic [19:0] guard_ms;
		logic [31:0] boot_time;
	} cfg_t;

	localparam entry_t ENTRY_RESET = '{coil: 1'b0, pulse: 1'b0, cool: 1'b0, guard: 1'b1,
		pstart: 32'd0, cstart: 32'd0, count: 16'd0};

endpackage

// ===== rtl/maglock_pulse_guard_controller.sv =====
// ---------------------------------------------------------------------------
// maglock_pulse_guard_controller
// Magnetic lock coil controller with pulse, cutoff, cooldown and boot guard.
// ---------------------------------------------------------------------------
// Usage:
//  Command beats (cmd_valid/cmd_stall, payload cmd) carry tick, open, close,
//  set level and force-all-off. Status beats (sts_valid/sts_stall, payload
//  sts) report each lock change; the final beat of a command has last set,
//  and a tick or force-all-off that changes nothing gives no beat at all.
//  Lock state sits in a one-port-read, one-port-write memory with a
//  registered read. Each lock visit passes a read state, a modify/write
//  state and an emit state that sends its status beats; a finish state
//  then closes each command.
//  The command channel stalls until the previous command is fully emitted.
//  A stalled status channel holds the output register; the engine parks one
//  more beat in a pending register, then waits.
//  Reset clears all control state; every memory entry reads as its reset
//  value (guard set, all else clear) until first written, so no clear pass.
//  Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
//  belong in idle time.
// ---------------------------------------------------------------------------
module maglock_pulse_guard_controller #(
	parameter int NUM_LOCKS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  mpg_pkg::cmd_t                   cmd,
	output logic                            sts_valid,
	input  logic                            sts_stall,
	output mpg_pkg::sts_t                   sts,
	input  logic                            cfg_we,
	input  logic [mpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mpg_pkg::*;

	localparam int AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

	cfg_t          cfg_q;
	logic [AW-1:0] mem_addr;
	entry_t        mem_rdata, mem_wdata;
	logic          mem_we;

	// register file; hold values between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_mask   <= 4'd0;
			cfg_q.enabled     <= 1'b0;
			cfg_q.pulse_ms    <= 20'd500;
			cfg_q.cutoff_ms   <= 20'd2000;
			cfg_q.cooldown_ms <= 20'd2000;
			cfg_q.guard_ms    <= 20'd5000;
			cfg_q.boot_time   <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE_MASK: cfg_q.mode_mask   <= cfg_data[3:0];
				REG_ENABLED:   cfg_q.enabled     <= cfg_data[0];
				REG_PULSE:     cfg_q.pulse_ms    <= cfg_data[19:0];
				REG_CUTOFF:    cfg_q.cutoff_ms   <= cfg_data[19:0];
				REG_COOLDOWN:  cfg_q.cooldown_ms <= cfg_data[19:0];
				REG_GUARD:     cfg_q.guard_ms    <= cfg_data[19:0];
				REG_BOOT_TIME: cfg_q.boot_time   <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-lock state store
	mpg_state_mem #(
		.DEPTH(NUM_LOCKS),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.raddr (mem_addr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata)
	);

	// sequence commands over the locks and emit status beats
	mpg_engine #(
		.NUM_LOCKS(NUM_LOCKS),
		.AW       (AW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.sts_valid(sts_valid),
		.sts_stall(sts_stall),
		.sts      (sts),
		.mem_addr (mem_addr),
		.mem_rdata(mem_rdata),
		.mem_we   (mem_we),
		.mem_wdata(mem_wdata)
	);

endmodule

// ===== rtl/mpg_state_mem.sv =====
// ---------------------------------------------------------------------------
// mpg_state_mem
// Per-lock state memory, one write and one registered read port.
// ---------------------------------------------------------------------------
module mpg_state_mem #(
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [AW-1:0]   raddr,
	output mpg_pkg::entry_t rdata,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  mpg_pkg::entry_t wdata
);
	import mpg_pkg::*;

	entry_t           mem [DEPTH];
	entry_t           rd_q;
	logic [DEPTH-1:0] valid_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvld_q <= valid_q[raddr];
		end
	end

	// an entry never written reads as its reset value
	assign rdata = rvld_q ? rd_q : ENTRY_RESET;

endmodule

// ===== rtl/mpg_engine.sv =====
// ---------------------------------------------------------------------------
// mpg_engine
// Command sequencer: read-modify-write of lock state and status beat output.
// ---------------------------------------------------------------------------
module mpg_engine #(
	parameter int NUM_LOCKS = 4,
	parameter int AW        = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mpg_pkg::cfg_t   cfg,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  mpg_pkg::cmd_t   cmd,
	output logic            sts_valid,
	input  logic            sts_stall,
	output mpg_pkg::sts_t   sts,
	output logic [AW-1:0]   mem_addr,
	input  mpg_pkg::entry_t mem_rdata,
	output logic            mem_we,
	output mpg_pkg::entry_t mem_wdata
);
	import mpg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EX   = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    op_q;
	logic [31:0]   now_q;
	logic          lvl_q;
	logic          boot_ok_q;
	logic [AW-1:0] i_q;
	logic [3:0]    cnt_q;
	logic [1:0]    ne_q, e_q;
	sts_t          slot_q [3];
	sts_t          pend_q, out_q;
	logic          pend_v_q, out_v_q;

	entry_t        cur, nxt;
	sts_t          slot_d [3];
	logic [1:0]    ne_d;
	logic [3:0]    i4;
	logic [1:0]    id;
	logic          secure, multi, out_free;
	logic [31:0]   pel, cel;
	logic          pulse_due, cut_due, cool_due;
	logic          out_load;
	sts_t          pend_last;

	function automatic sts_t mk(entry_t s, logic [1:0] lid, logic [3:0] st);
		sts_t r;
		r.lock_id     = lid;
		r.coil_on     = s.coil;
		r.is_pulsing  = s.pulse;
		r.in_cooldown = s.cool;
		r.guarded     = s.guard;
		r.pulses_done = s.count;
		r.status      = st;
		r.last        = 1'b0;
		return r;
	endfunction

	assign cur      = mem_rdata;
	assign i4       = 4'(i_q);
	assign id       = i4[1:0];
	assign secure   = (i4 < 4'd4) && cfg.mode_mask[i4[1:0]];
	assign multi    = (op_q == OP_TICK) || (op_q == OP_FORCE);
	assign out_free = !out_v_q || !sts_stall;
	assign pel      = now_q - cur.pstart;
	assign cel      = now_q - cur.cstart;
	assign pulse_due = pel >= {12'd0, cfg.pulse_ms};
	assign cut_due   = pel >= {12'd0, cfg.cutoff_ms};
	assign cool_due  = cel >= {12'd0, cfg.cooldown_ms};

	// load the output register from pending in emit or finish
	assign out_load = pend_v_q && out_free && ((state_q == S_FIN)
		|| (state_q == S_EMIT && e_q != ne_q && cnt_q != 4'(MAX_ITEMS)));

	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	always_comb begin
		nxt       = cur;
		ne_d      = 2'd0;
		slot_d[0] = '0;
		slot_d[1] = '0;
		slot_d[2] = '0;
		case (op_q)
			OP_TICK: begin
				if (secure) begin
					if (nxt.guard && boot_ok_q) begin
						nxt.guard    = 1'b0;
						slot_d[ne_d] = mk(nxt, id, ST_GUARD_CLR);
						ne_d         = ne_d + 2'd1;
					end
					if (nxt.cool && cool_due) begin
						nxt.cool     = 1'b0;
						slot_d[ne_d] = mk(nxt, id, ST_COOL_CLR);
						ne_d         = ne_d + 2'd1;
					end
					if ((nxt.pulse && pulse_due) || (nxt.coil && cut_due)) begin
						slot_d[ne_d].status = (nxt.pulse && pulse_due) ? ST_PULSE_DONE
							: ST_CUTOFF;
						nxt.coil   = 1'b0;
						nxt.pulse  = 1'b0;
						nxt.cool   = 1'b1;
						nxt.guard  = 1'b0;
						nxt.cstart = now_q;
						slot_d[ne_d] = mk(nxt, id, slot_d[ne_d].status);
						ne_d       = ne_d + 2'd1;
					end
				end
			end
			OP_FORCE: begin
				if (secure) begin
					nxt.coil   = 1'b0;
					nxt.pulse  = 1'b0;
					nxt.cool   = 1'b1;
					nxt.guard  = 1'b0;
					nxt.cstart = now_q;
					if (cur.coil || cur.pulse) begin
						slot_d[0] = mk(nxt, id, ST_FORCED);
						ne_d      = 2'd1;
					end
				end
			end
			OP_OPEN: begin
				ne_d = 2'd1;
				if (!cfg.enabled) begin
					slot_d[0] = mk(nxt, id, ST_REJECT);
				end else if (!secure) begin
					nxt.coil  = 1'b0;
					nxt.pulse = 1'b0;
					nxt.cool  = 1'b0;
					nxt.guard = 1'b0;
					slot_d[0] = mk(nxt, id, ST_OPENED);
				end else if (cur.guard && !boot_ok_q) begin
					slot_d[0] = mk(nxt, id, ST_BLK_BOOT);
				end else if (cur.cool && !cool_due) begin
					slot_d[0] = mk(nxt, id, ST_BLK_COOL);
				end else if (cur.pulse || cur.coil) begin
					slot_d[0] = mk(nxt, id, ST_BUSY);
				end else begin
					nxt.coil   = 1'b1;
					nxt.pulse  = 1'b1;
					nxt.cool   = 1'b0;
					nxt.guard  = 1'b0;
					nxt.pstart = now_q;
					nxt.count  = cur.count + 16'd1;
					slot_d[0]  = mk(nxt, id, ST_OPENED);
				end
			end
			OP_CLOSE: begin
				ne_d = 2'd1;
				if (!cfg.enabled) begin
					slot_d[0] = mk(nxt, id, ST_REJECT);
				end else begin
					nxt.coil  = !secure;
					nxt.pulse = 1'b0;
					nxt.cool  = secure;
					nxt.guard = 1'b0;
					if (secure) begin
						nxt.cstart = now_q;
					end
					slot_d[0] = mk(nxt, id, ST_CLOSED);
				end
			end
			OP_LEVEL: begin
				ne_d = 2'd1;
				if (secure) begin
					slot_d[0] = mk(nxt, id, ST_REJECT);
				end else begin
					nxt.coil  = lvl_q;
					nxt.pulse = 1'b0;
					nxt.cool  = 1'b0;
					nxt.guard = 1'b0;
					slot_d[0] = mk(nxt, id, ST_LEVEL);
				end
			end
			default: ;
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign sts_valid = out_v_q;
	assign sts       = out_q;
	assign mem_addr  = i_q;
	assign mem_we    = (state_q == S_EX);
	assign mem_wdata = nxt;

	// output valid: set on a load, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (!sts_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q      <= cmd.operation;
						now_q     <= cmd.time_ms;
						lvl_q     <= cmd.closed_level;
						boot_ok_q <= (cmd.time_ms - cfg.boot_time) >= {12'd0, cfg.guard_ms};
						cnt_q     <= 4'd0;
						if (cmd.operation == OP_TICK || cmd.operation == OP_FORCE) begin
							i_q     <= '0;
							state_q <= S_RD;
						end else if (cmd.operation == OP_OPEN || cmd.operation == OP_CLOSE
							|| cmd.operation == OP_LEVEL) begin
							if (5'(cmd.lock_index) >= 5'(NUM_LOCKS)) begin
								pend_q   <= '{lock_id: cmd.lock_index, status: ST_REJECT,
									default: '0};
								pend_v_q <= 1'b1;
								cnt_q    <= 4'd1;
								state_q  <= S_FIN;
							end else begin
								i_q     <= AW'(cmd.lock_index);
								state_q <= S_RD;
							end
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: begin
					slot_q  <= slot_d;
					ne_q    <= ne_d;
					e_q     <= 2'd0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (e_q == ne_q) begin
						if (multi && i_q != AW'(NUM_LOCKS - 1)) begin
							i_q     <= i_q + AW'(1);
							state_q <= S_RD;
						end else begin
							state_q <= S_FIN;
						end
					end else if (cnt_q == 4'(MAX_ITEMS)) begin
						// drop beats past the per-command limit
						e_q <= e_q + 2'd1;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_q <= pend_q;
						end
						pend_q   <= slot_q[e_q];
						pend_v_q <= 1'b1;
						e_q      <= e_q + 2'd1;
						cnt_q    <= cnt_q + 4'd1;
					end
				end
				S_FIN: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q    <= pend_last;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== verif/mpg_status_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mpg_status_checker
// Watches the command, status and register ports of the lock controller,
// predicts the status beats of each command and compares them in order.
// ---------------------------------------------------------------------------
module mpg_status_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_stall,
	input  mpg_pkg::cmd_t                   cmd,
	input  logic                            sts_valid,
	input  logic                            sts_stall,
	input  mpg_pkg::sts_t                   sts,
	input  logic                            cfg_we,
	input  logic [mpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatches,
	output int                              beats_due
);
	import mpg_pkg::*;

	localparam int LOCKS = 4;

	logic [3:0]  mode_mask;
	logic        en;
	logic [19:0] pulse_len, cutoff_len, cool_len, guard_len;
	logic [31:0] boot_t;

	logic        coil   [LOCKS];
	logic        pulse  [LOCKS];
	logic        cool   [LOCKS];
	logic        guard  [LOCKS];
	logic [31:0] pstart [LOCKS];
	logic [31:0] cstart [LOCKS];
	logic [15:0] count  [LOCKS];

	sts_t status_due[$];
	sts_t beat_list[$];

	function automatic void post_beat(int k, logic [3:0] st);
		sts_t s;
		s.lock_id     = k[1:0];
		s.coil_on     = coil[k];
		s.is_pulsing  = pulse[k];
		s.in_cooldown = cool[k];
		s.guarded     = guard[k];
		s.pulses_done = count[k];
		s.status      = st;
		s.last        = 1'b0;
		if (beat_list.size() < MAX_ITEMS)
			beat_list.push_back(s);
	endfunction

	function automatic void coil_off(int k, logic [31:0] now);
		coil[k]   = 1'b0;
		pulse[k]  = 1'b0;
		cool[k]   = 1'b1;
		guard[k]  = 1'b0;
		cstart[k] = now;
	endfunction

	function automatic void hold_coil(int k, logic lvl);
		coil[k]  = lvl;
		pulse[k] = 1'b0;
		cool[k]  = 1'b0;
		guard[k] = 1'b0;
	endfunction

	// Work out the status beats of one command and queue them.
	function automatic void predict_lock_step(cmd_t c);
		int k;
		logic [31:0] now;
		logic was_on;
		k = c.lock_index;
		now = c.time_ms;
		beat_list.delete();
		case (c.operation)
			OP_TICK: begin
				for (int i = 0; i < LOCKS; i++) begin
					if (!mode_mask[i])
						continue;
					if (guard[i] && (now - boot_t) >= {12'd0, guard_len}) begin
						guard[i] = 1'b0;
						post_beat(i, ST_GUARD_CLR);
					end
					if (cool[i] && (now - cstart[i]) >= {12'd0, cool_len}) begin
						cool[i] = 1'b0;
						post_beat(i, ST_COOL_CLR);
					end
					if (pulse[i] && (now - pstart[i]) >= {12'd0, pulse_len}) begin
						coil_off(i, now);
						post_beat(i, ST_PULSE_DONE);
					end else if (coil[i] && (now - pstart[i]) >= {12'd0, cutoff_len}) begin
						coil_off(i, now);
						post_beat(i, ST_CUTOFF);
					end
				end
			end
			OP_FORCE: begin
				for (int i = 0; i < LOCKS; i++) begin
					if (!mode_mask[i])
						continue;
					was_on = coil[i] || pulse[i];
					coil_off(i, now);
					if (was_on)
						post_beat(i, ST_FORCED);
				end
			end
			OP_LEVEL: begin
				if (mode_mask[k]) begin
					post_beat(k, ST_REJECT);
				end else begin
					hold_coil(k, c.closed_level);
					post_beat(k, ST_LEVEL);
				end
			end
			OP_OPEN, OP_CLOSE: begin
				if (!en) begin
					post_beat(k, ST_REJECT);
				end else if (c.operation == OP_CLOSE) begin
					if (mode_mask[k])
						coil_off(k, now);
					else
						hold_coil(k, 1'b1);
					post_beat(k, ST_CLOSED);
				end else if (!mode_mask[k]) begin
					hold_coil(k, 1'b0);
					post_beat(k, ST_OPENED);
				end else if (guard[k] && (now - boot_t) < {12'd0, guard_len}) begin
					post_beat(k, ST_BLK_BOOT);
				end else if (cool[k] && (now - cstart[k]) < {12'd0, cool_len}) begin
					post_beat(k, ST_BLK_COOL);
				end else if (pulse[k] || coil[k]) begin
					post_beat(k, ST_BUSY);
				end else begin
					coil[k]   = 1'b1;
					pulse[k]  = 1'b1;
					cool[k]   = 1'b0;
					guard[k]  = 1'b0;
					pstart[k] = now;
					count[k]  = count[k] + 16'd1;
					post_beat(k, ST_OPENED);
				end
			end
			default: ;
		endcase
		if (beat_list.size() > 0)
			beat_list[beat_list.size()-1].last = 1'b1;
		foreach (beat_list[j])
			status_due.push_back(beat_list[j]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sts_t want;
		if (!arst_n) begin
			mode_mask  = 4'd0;
			en         = 1'b0;
			pulse_len  = 20'd500;
			cutoff_len = 20'd2000;
			cool_len   = 20'd2000;
			guard_len  = 20'd5000;
			boot_t     = 32'd0;
			for (int i = 0; i < LOCKS; i++) begin
				coil[i]   = 1'b0;
				pulse[i]  = 1'b0;
				cool[i]   = 1'b0;
				guard[i]  = 1'b1;
				pstart[i] = 32'd0;
				cstart[i] = 32'd0;
				count[i]  = 16'd0;
			end
			status_due.delete();
			mismatches = 0;
			beats_due  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE_MASK: mode_mask  = cfg_data[3:0];
					REG_ENABLED:   en         = cfg_data[0];
					REG_PULSE:     pulse_len  = cfg_data[19:0];
					REG_CUTOFF:    cutoff_len = cfg_data[19:0];
					REG_COOLDOWN:  cool_len   = cfg_data[19:0];
					REG_GUARD:     guard_len  = cfg_data[19:0];
					REG_BOOT_TIME: boot_t     = cfg_data;
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				predict_lock_step(cmd);
			if (sts_valid && !sts_stall) begin
				if (status_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status beat with none due: %p", sts);
				end else begin
					want = status_due.pop_front();
					if (sts !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("status mismatch: expected %p, got %p", want, sts);
					end
				end
			end
			beats_due = status_due.size();
		end
	end

endmodule

// ===== verif/maglock_pulse_guard_controller_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// maglock_pulse_guard_controller_tb
// Drives lock commands and register settings into the controller, with random
// gaps and stalls; the status checker beside it predicts and compares beats.
// ---------------------------------------------------------------------------
module maglock_pulse_guard_controller_tb;
	import mpg_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_stall;
	cmd_t                  cmd;
	logic                  sts_valid;
	logic                  sts_stall;
	sts_t                  sts;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    beats_due;

	int          phase;       // which stimulus stage is running
	logic [31:0] clock_ms;    // millisecond time carried by commands
	int          quiet_cycles;

	maglock_pulse_guard_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.sts_valid(sts_valid), .sts_stall(sts_stall), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mpg_status_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.sts_valid(sts_valid), .sts_stall(sts_stall), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .beats_due(beats_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (sts_valid && !sts_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Status receiver: random stall bursts, one long hold in stage four so the
	// controller backs up into its command input, and no stalls in the last stage.
	initial begin
		bit held;
		held = 1'b0;
		sts_stall <= 1'b0;
		forever begin
			if (phase == 4 && !held) begin
				held = 1'b1;
				sts_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else if (phase != 5 && $urandom_range(0, 3) == 0) begin
				sts_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				sts_stall <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Hold the beat until it is taken; valid stays up for a following beat.
	task automatic send_beat(logic [2:0] op, logic [1:0] idx, logic [31:0] t, logic lvl);
		cmd_valid <= 1'b1;
		cmd <= '{operation: op, lock_index: idx, time_ms: t, closed_level: lvl};
		do
			@(posedge clk);
		while (cmd_stall);
		if (phase != 5 && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop valid and let every due beat drain, then wait out a silent command.
	task automatic drain;
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (beats_due != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_timing(logic [3:0] mask, logic en, logic [19:0] p, logic [19:0] c,
		logic [19:0] cd, logic [19:0] g, logic [31:0] boot);
		write_reg(REG_MODE_MASK, {28'd0, mask});
		write_reg(REG_ENABLED, {31'd0, en});
		write_reg(REG_PULSE, {12'd0, p});
		write_reg(REG_CUTOFF, {12'd0, c});
		write_reg(REG_COOLDOWN, {12'd0, cd});
		write_reg(REG_GUARD, {12'd0, g});
		write_reg(REG_BOOT_TIME, boot);
	endtask

	// Mostly ticks and opens in small steps of time, with the odd
	// large jump, close, level, force-all-off or unused operation mixed in.
	task automatic random_beat;
		int pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 35)       op = OP_TICK;
		else if (pick < 65)  op = OP_OPEN;
		else if (pick < 75)  op = OP_CLOSE;
		else if (pick < 90)  op = OP_LEVEL;
		else if (pick < 95)  op = OP_FORCE;
		else                 op = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 9) < 8)
			clock_ms = clock_ms + $urandom_range(0, 12);
		else
			clock_ms = clock_ms + $urandom_range(0, 2000);
		send_beat(op, 2'($urandom_range(0, 3)), clock_ms, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [31:0] base;
		phase        = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: guard, pulse, busy, cooldown, force-all-off and reject cases.
		load_timing(4'hF, 1'b1, 20'd5, 20'd10, 20'd8, 20'd20, 32'd100);
		send_beat(OP_OPEN, 2'd0, 32'd100, 1'b0);
		send_beat(OP_TICK, 2'd0, 32'd119, 1'b0);
		send_beat(OP_TICK, 2'd0, 32'd120, 1'b0);
		send_beat(OP_OPEN, 2'd0, 32'd121, 1'b0);
		send_beat(OP_OPEN, 2'd0, 32'd122, 1'b0);
		send_beat(OP_TICK, 2'd0, 32'd126, 1'b0);
		send_beat(OP_OPEN, 2'd0, 32'd127, 1'b0);
		send_beat(OP_TICK, 2'd0, 32'd134, 1'b0);
		send_beat(OP_OPEN, 2'd1, 32'd135, 1'b0);
		send_beat(OP_FORCE, 2'd0, 32'd136, 1'b0);
		send_beat(OP_CLOSE, 2'd2, 32'd137, 1'b0);
		send_beat(OP_LEVEL, 2'd3, 32'd138, 1'b1);
		send_beat(3'd5, 2'd1, 32'd139, 1'b0);
		send_beat(3'd6, 2'd2, 32'd140, 1'b1);
		send_beat(3'd7, 2'd3, 32'd141, 1'b0);
		drain();
		// Disabled, with two fail-safe locks.
		write_reg(REG_ENABLED, 32'd0);
		write_reg(REG_MODE_MASK, 32'h5);
		send_beat(OP_OPEN, 2'd1, 32'd200, 1'b0);
		send_beat(OP_CLOSE, 2'd2, 32'd201, 1'b0);
		send_beat(OP_LEVEL, 2'd1, 32'd202, 1'b1);
		send_beat(OP_LEVEL, 2'd3, 32'd203, 1'b0);
		drain();
		// Lock 1 turns fail-secure with its coil held on: cutoff with no pulse.
		load_timing(4'h7, 1'b1, 20'hFFFFF, 20'd10, 20'd0, 20'd0, 32'hFFFF_FFF0);
		send_beat(OP_TICK, 2'd0, 32'hFFFF_FFFF, 1'b0);
		send_beat(OP_OPEN, 2'd3, 32'd0, 1'b0);
		send_beat(OP_CLOSE, 2'd3, 32'd1, 1'b0);
		send_beat(OP_OPEN, 2'd0, 32'd2, 1'b0);
		send_beat(OP_TICK, 2'd0, 32'd20, 1'b0);
		drain();

		// Random stages, each with its own timing; extremes in stages one and two.
		for (int ph = 0; ph < 6; ph++) begin
			phase = ph;
			base = $urandom;
			clock_ms = base;
			case (ph)
				1: load_timing(4'($urandom), 1'b1, 20'd0, 20'd0, 20'd0, 20'd0, base);
				2: load_timing(4'($urandom), 1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
					20'hFFFFF, base - 32'hFFFF0);
				3: load_timing(4'($urandom), 1'b0, 20'($urandom_range(1, 20)),
					20'($urandom_range(1, 40)), 20'($urandom_range(1, 30)),
					20'($urandom_range(0, 50)), base);
				default: load_timing(4'($urandom), 1'b1, 20'($urandom_range(1, 20)),
					20'($urandom_range(1, 40)), 20'($urandom_range(1, 30)),
					20'($urandom_range(0, 50)), base);
			endcase
			repeat (50)
				random_beat();
			drain();
		end

		if (mismatches == 0 && beats_due == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mpg_pkg.sv
rtl/mpg_state_mem.sv
rtl/mpg_engine.sv
rtl/maglock_pulse_guard_controller.sv
verif/mpg_status_checker.sv
verif/maglock_pulse_guard_controller_tb.sv
